### src/rgb_to_hsv_convert_assert.svh
// Assertion macros used by the colour conversion RTL.
`ifndef RGB_TO_HSV_CONVERT_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

### src/rth_pkg.sv
`timescale 1ns / 1ps

package rth_pkg;

   localparam int CHANNEL_BITS  = 8;
   localparam int HUE_FRAC_BITS = 4;

   localparam int CHAN_FULL     = (1 << CHANNEL_BITS) - 1;
   localparam int SECTOR_UNIT   = 60 << HUE_FRAC_BITS;
   localparam int UNIT_BITS     = $clog2(SECTOR_UNIT + 1);
   localparam int HUE_BITS      = $clog2(6 * SECTOR_UNIT);

   localparam int HUE_NUM_BITS  = CHANNEL_BITS + UNIT_BITS;
   localparam int HUE_Q_BITS    = UNIT_BITS;
   localparam int SAT_NUM_BITS  = 2 * CHANNEL_BITS;
   localparam int SAT_Q_BITS    = CHANNEL_BITS;
   localparam int DIV_STEPS     = (HUE_Q_BITS > SAT_Q_BITS) ? HUE_Q_BITS : SAT_Q_BITS;

   localparam int REQ_DATA_BITS = ((3 * CHANNEL_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((HUE_BITS + 2 * CHANNEL_BITS + 7) / 8) * 8;

   typedef logic [CHANNEL_BITS-1:0] chan_type;
   typedef logic [HUE_BITS-1:0]     hue_type;

   localparam hue_type HUE_OFS_GREEN = hue_type'(2 * SECTOR_UNIT);
   localparam hue_type HUE_OFS_BLUE  = hue_type'(4 * SECTOR_UNIT);
   localparam hue_type HUE_OFS_WRAP  = hue_type'(6 * SECTOR_UNIT);

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   typedef struct packed {
      chan_type   diff;
      chan_type   delta;
      chan_type   value;
      sector_type sector;
      logic       neg;
   } front_type;

   typedef struct packed {
      logic [HUE_NUM_BITS-1:0] hue_rem;
      logic [HUE_Q_BITS-1:0]   hue_quo;
      logic [SAT_NUM_BITS-1:0] sat_rem;
      logic [SAT_Q_BITS-1:0]   sat_quo;
      chan_type                delta;
      chan_type                value;
      sector_type              sector;
      logic                    neg;
   } div_type;

endpackage

### src/rgb_to_hsv_convert.sv
// From an accepted request to its result on the rsp side a pixel passes through
// the front stage, scaling stage, ten divider stages and output register.
// Throughput: one pixel per cycle unless rsp_tready stalls; the two restoring
// dividers retire up to one bit per stage, so a new pixel may enter every clock.
// Reset clears the stage valid bits only; no result is pending after reset.
`timescale 1ns / 1ps
`include "rgb_to_hsv_convert_assert.svh"

module rgb_to_hsv_convert (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  logic [rth_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hue [12:0], saturation [20:13], brightness [28:21], zero padding above
   output logic [rth_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // achromatic [0]
   output logic                               rsp_tuser
);
   import rth_pkg::*;

   localparam int STAGES = DIV_STEPS + 3;
   localparam int LAST   = STAGES - 1;

   logic [STAGES-1:0] vld_ff, vld_in, adv;

   front_type front_ff, front_in;
   div_type   div_ff [DIV_STEPS+1];
   div_type   div_in [DIV_STEPS+1];

   hue_type  hue_ff, hue_in;
   chan_type sat_ff, sat_in;
   chan_type val_ff, val_in;
   logic     achro_ff, achro_in;

   chan_type red, green, blue, max_c, min_c, op_a, op_b;

   // A stage moves on when it is empty or when the stage after it moves on,
   // so bubbles are squeezed out while the output is stalled.
   always_comb begin
      adv[LAST] = !vld_ff[LAST] || rsp_tready;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = adv[0] ? req_tvalid : vld_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   assign req_tready = adv[0];

   // Front stage: maximum, minimum, sector and signed channel difference.
   always_comb begin
      red   = req_tdata[0 +: CHANNEL_BITS];
      green = req_tdata[CHANNEL_BITS +: CHANNEL_BITS];
      blue  = req_tdata[2*CHANNEL_BITS +: CHANNEL_BITS];

      max_c = (red >= green) ? red : green;
      if (blue > max_c) begin
         max_c = blue;
      end
      min_c = (red <= green) ? red : green;
      if (blue < min_c) begin
         min_c = blue;
      end

      priority if (red >= green && red >= blue) begin
         front_in.sector = SECT_RED;
         op_a            = green;
         op_b            = blue;
      end else if (green >= blue) begin
         front_in.sector = SECT_GREEN;
         op_a            = blue;
         op_b            = red;
      end else begin
         front_in.sector = SECT_BLUE;
         op_a            = red;
         op_b            = green;
      end

      front_in.neg   = op_a < op_b;
      front_in.diff  = front_in.neg ? (op_b - op_a) : (op_a - op_b);
      front_in.delta = max_c - min_c;
      front_in.value = max_c;
   end

   // Scaling stage and the divider steps. Each step tries the divisor shifted to
   // the current quotient bit and keeps the subtraction when it fits.
   always_comb begin
      logic [HUE_NUM_BITS-1:0] hue_trial;
      logic [SAT_NUM_BITS-1:0] sat_trial;

      div_in[0].hue_rem = HUE_NUM_BITS'(SECTOR_UNIT * front_ff.diff);
      div_in[0].hue_quo = '0;
      div_in[0].sat_rem = SAT_NUM_BITS'(CHAN_FULL * front_ff.delta);
      div_in[0].sat_quo = '0;
      div_in[0].delta   = front_ff.delta;
      div_in[0].value   = front_ff.value;
      div_in[0].sector  = front_ff.sector;
      div_in[0].neg     = front_ff.neg;

      for (int k = 0; k < DIV_STEPS; k++) begin
         div_in[k+1] = div_ff[k];
         hue_trial   = HUE_NUM_BITS'(div_ff[k].delta) << (HUE_Q_BITS - 1 - k);
         sat_trial   = SAT_NUM_BITS'(div_ff[k].value) << (SAT_Q_BITS - 1 - k);
         if (k < HUE_Q_BITS) begin
            if (div_ff[k].hue_rem >= hue_trial) begin
               div_in[k+1].hue_rem = div_ff[k].hue_rem - hue_trial;
               div_in[k+1].hue_quo = {div_ff[k].hue_quo[HUE_Q_BITS-2:0], 1'b1};
            end else begin
               div_in[k+1].hue_quo = {div_ff[k].hue_quo[HUE_Q_BITS-2:0], 1'b0};
            end
         end
         if (k < SAT_Q_BITS) begin
            if (div_ff[k].sat_rem >= sat_trial) begin
               div_in[k+1].sat_rem = div_ff[k].sat_rem - sat_trial;
               div_in[k+1].sat_quo = {div_ff[k].sat_quo[SAT_Q_BITS-2:0], 1'b1};
            end else begin
               div_in[k+1].sat_quo = {div_ff[k].sat_quo[SAT_Q_BITS-2:0], 1'b0};
            end
         end
      end
   end

   // Output stage: place the sector quotient around the sector offset, flag grey pixels.
   always_comb begin
      hue_type mag;

      mag = hue_type'(div_ff[DIV_STEPS].hue_quo);
      unique case (div_ff[DIV_STEPS].sector)
         SECT_RED: begin
            hue_in = div_ff[DIV_STEPS].neg ? (HUE_OFS_WRAP - mag) : mag;
         end
         SECT_GREEN: begin
            hue_in = div_ff[DIV_STEPS].neg ? (HUE_OFS_GREEN - mag) : (HUE_OFS_GREEN + mag);
         end
         SECT_BLUE: begin
            hue_in = div_ff[DIV_STEPS].neg ? (HUE_OFS_BLUE - mag) : (HUE_OFS_BLUE + mag);
         end
         default: begin
            hue_in = '0;
         end
      endcase

      // Equal channels divide by zero; the quotient is discarded here.
      achro_in = div_ff[DIV_STEPS].delta == '0;
      if (achro_in) begin
         hue_in = '0;
      end
      sat_in = (div_ff[DIV_STEPS].value == '0) ? '0 : div_ff[DIV_STEPS].sat_quo;
      val_in = div_ff[DIV_STEPS].value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         front_ff <= front_in;
      end
      for (int k = 0; k <= DIV_STEPS; k++) begin
         if (adv[k+1]) begin
            div_ff[k] <= div_in[k];
         end
      end
      if (adv[LAST]) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         val_ff   <= val_in;
         achro_ff <= achro_in;
      end
   end

   assign rsp_tvalid = vld_ff[LAST];
   assign rsp_tdata  = RSP_DATA_BITS'({val_ff, sat_ff, hue_ff});
   assign rsp_tuser  = achro_ff;

   `ASSERT_IMPLY(a_achromatic_clears, clock, reset, rsp_tvalid && rsp_tuser, hue_ff == '0 && sat_ff == '0)
   `ASSERT_IMPLY(a_hue_in_range, clock, reset, rsp_tvalid, hue_ff < HUE_OFS_WRAP)
   `ASSERT_IMPLY(a_black_is_grey, clock, reset, rsp_tvalid && val_ff == '0, achro_ff && sat_ff == '0)
   `ASSERT_IMPLY(a_block_only_full, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)
   `ASSERT_NEXT(a_front_holds, clock, reset, vld_ff[0] && !adv[0], vld_ff[0])

endmodule
